// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/scii_pkg.sv
// Package for the sampled curve interpolator and integrator.
// Types, codes and widths shared by controller, datapath and top level.
`default_nettype none
package scii_pkg;

    localparam int TABLE_DEPTH_DEF = 512;
    localparam int NUM_W  = 50;
    localparam int PROD_W = NUM_W + 2;
    localparam int ACC_W  = 56;
    localparam int DEN_W  = 17;
    localparam int DIV_CW = $clog2(NUM_W + 1);
    localparam int APB_AW = 4;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EVAL  = 2'd1;
    localparam logic [1:0] ACT_INTEG = 2'd2;

    localparam logic [1:0] REG_FIRST_WL = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_COUNT    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SPAN  = 2'd1,
        ST_INDEX = 2'd2,
        ST_ORDER = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_WRITE, OP_ZERO, OP_CLIP, OP_RD0, OP_TAKE0, OP_RES_Y,
        OP_DIV_X, OP_CLAMP, OP_RD_I, OP_RD_I1, OP_GET_V1, OP_MUL_D, OP_NUM,
        OP_DIV_N, OP_INTERP_END, OP_MUL_EDGE, OP_RD_P, OP_MUL_FIRST, OP_ACC_SET,
        OP_WALK_START, OP_WALK, OP_MUL_LAST, OP_ACC_ADD, OP_RES_ACC, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    xsel_b;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic act_write;
        logic act_eval;
        logic act_integ;
        logic idx_ok;
        logic span_zero;
        logic lo_eq_f;
        logic lo_out;
        logic lo_gt_hi;
        logic lo_eq_hi;
        logic a_gt_b;
        logic a_eq_b;
        logic p_gt_q;
        logic div_busy;
        logic walk_done;
    } dp_flags_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_EVAL_CHK, S_INT_CHK, S_RD0, S_TAKE0, S_RES_Y,
        S_DIVX, S_DIVX_W, S_CLAMP, S_RD_I, S_RD_I1, S_GET_V1, S_MUL_D, S_NUM,
        S_DIVN, S_DIVN_W, S_IEND, S_INT_PQ, S_EDGE_MUL, S_EDGE_ACC, S_RD_P,
        S_FIRST_MUL, S_FIRST_ACC, S_WALK_START, S_WALK, S_LAST_MUL, S_LAST_ACC,
        S_RES_ACC, S_EMIT
    } ctrl_state_t;

endpackage
`default_nettype wire

// File: hdl/scii_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module scii_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: hdl/scii_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on scii_pkg for operand widths.
`default_nettype none
module scii_div
    import scii_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [DIV_CW-1:0] iters,
    output logic                   busy,
    output logic      [NUM_W-1:0]  quo,
    output logic      [DEN_W-1:0]  rem
);

    logic [NUM_W-1:0]  qn_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic [DEN_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, qn_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - DIV_CW'(1);
            busy_reg <= cnt_reg != DIV_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qn_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            qn_reg  <= {qn_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        end
    end

    assign busy = busy_reg;
    assign quo  = qn_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// File: hdl/scii_dp.sv
// Datapath: operand registers, shared multiplier, sample RAM, divider, accumulator.
// Depends on scii_pkg, scii_ram and scii_div; driven by scii_ctrl commands.
`default_nettype none
module scii_dp
    import scii_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    output dp_flags_t               flags,
    input  wire logic [1:0]         in_action,
    input  wire logic [8:0]         in_index,
    input  wire logic signed [31:0] in_value,
    input  wire logic [15:0]        in_lo,
    input  wire logic [15:0]        in_hi,
    input  wire logic [15:0]        first_wl,
    input  wire logic [15:0]        step,
    input  wire logic [9:0]         count,
    output logic signed [63:0]      out_result,
    output status_t                 out_status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = IW + 17;

    logic [1:0]               act_reg;
    logic [8:0]               idx_reg;
    logic signed [31:0]       val_reg;
    logic [15:0]              lo_reg, hi_reg;
    logic [IW+15:0]           span_reg;
    logic [15:0]              xa_reg, xb_reg;
    logic [IW-1:0]            i_reg, p_reg, q_reg;
    logic [15:0]              r_reg, e_reg, rb_reg;
    logic signed [31:0]       v0_reg, v1_reg, y_reg, fa_reg, fb_reg, prev_reg;
    logic signed [32:0]       pair_reg;
    logic signed [PROD_W-1:0] prod_reg, num_reg;
    logic                     neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [63:0]       res_reg;
    status_t                  st_reg;
    logic [IW:0]              k_reg;
    logic                     rv_reg, pv_reg, mv_reg;
    logic signed [63:0]       out_res_reg;
    status_t                  out_st_reg;

    logic [IW:0]              n_val;
    logic [IW-1:0]            nm1;
    logic [SW-1:0]            fspan;
    logic [15:0]              a_val, b_val, x_sel;
    logic [15:0]              quo16, rem16;
    logic signed [32:0]       d_val;
    logic [15:0]              mul_a;
    logic signed [34:0]       mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic [PROD_W-1:0]        m_full;
    logic signed [PROD_W-1:0] sq, y_full;
    logic signed [ACC_W-1:0]  acc_half;
    logic                     iss;
    logic                     ram_we;
    logic [IW-1:0]            ram_addr;
    logic [31:0]              ram_rdata;
    logic                     div_start, div_busy;
    logic [NUM_W-1:0]         div_num, div_quo;
    logic [DEN_W-1:0]         div_den, div_rem;
    logic [DIV_CW-1:0]        div_iters;

    always_comb begin
        if (count == '0) begin
            n_val = (IW+1)'(1);
        end else if (32'(count) > 32'(TABLE_DEPTH)) begin
            n_val = (IW+1)'(TABLE_DEPTH);
        end else begin
            n_val = (IW+1)'(count);
        end
    end

    assign nm1   = IW'(n_val - (IW+1)'(1));
    assign fspan = SW'(first_wl) + SW'(span_reg);
    assign a_val = (lo_reg > first_wl) ? lo_reg : first_wl;
    assign b_val = (SW'(hi_reg) < fspan) ? hi_reg : 16'(fspan);
    assign x_sel = cmd.xsel_b ? xb_reg : xa_reg;
    assign quo16 = div_quo[15:0];
    assign rem16 = div_rem[15:0];
    assign d_val = 33'(v1_reg) - 33'(v0_reg);
    assign iss   = k_reg <= {1'b0, q_reg};

    always_comb begin
        case (cmd.op)
            OP_MUL_D: begin
                mul_a = r_reg;
                mul_b = 35'($signed({d_val, 1'b0}));
            end
            OP_MUL_EDGE: begin
                mul_a = xb_reg - xa_reg;
                mul_b = 35'(fa_reg) + 35'(fb_reg);
            end
            OP_MUL_FIRST: begin
                mul_a = e_reg;
                mul_b = 35'(fa_reg) + 35'($signed(ram_rdata));
            end
            OP_MUL_LAST: begin
                mul_a = rb_reg;
                mul_b = 35'(prev_reg) + 35'(fb_reg);
            end
            default: begin
                mul_a = step;
                mul_b = 35'(pair_reg);
            end
        endcase
    end

    assign prod_full = $signed({1'b0, mul_a}) * mul_b;
    assign m_full    = num_reg[PROD_W-1]
                       ? (-num_reg + PROD_W'({step, 1'b0}) - PROD_W'(1))
                       : num_reg;
    assign sq        = neg_reg ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
    assign y_full    = PROD_W'(v0_reg) + sq;
    assign acc_half  = (acc_reg + $signed(ACC_W'(1))) >>> 1;

    assign div_start = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_N);
    assign div_num   = (cmd.op == OP_DIV_N) ? NUM_W'(m_full) : {x_sel, {(NUM_W-16){1'b0}}};
    assign div_den   = (cmd.op == OP_DIV_N) ? {step, 1'b0} : {1'b0, step};
    assign div_iters = (cmd.op == OP_DIV_N) ? DIV_CW'(NUM_W) : DIV_CW'(16);

    always_comb begin
        case (cmd.op)
            OP_WRITE: ram_addr = IW'(idx_reg);
            OP_RD_I:  ram_addr = i_reg;
            OP_RD_I1: ram_addr = i_reg + IW'(1);
            OP_RD_P:  ram_addr = p_reg;
            OP_WALK:  ram_addr = k_reg[IW-1:0];
            default:  ram_addr = '0;
        endcase
    end

    assign ram_we = cmd.op == OP_WRITE;

    scii_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    scii_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .iters   (div_iters),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
            pv_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            rv_reg <= (cmd.op == OP_WALK) && iss;
            pv_reg <= rv_reg;
            mv_reg <= pv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        span_reg <= (IW+16)'(nm1) * (IW+16)'(step);
        if (rv_reg) begin
            pair_reg <= 33'(prev_reg) + 33'($signed(ram_rdata));
        end
        if (mv_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        case (cmd.op)
            OP_LOAD: begin
                act_reg <= in_action;
                idx_reg <= in_index;
                val_reg <= in_value;
                lo_reg  <= in_lo;
                hi_reg  <= in_hi;
            end
            OP_WRITE: begin
                res_reg <= '0;
                st_reg  <= ST_OK;
            end
            OP_ZERO: begin
                res_reg <= '0;
                st_reg  <= cmd.code;
            end
            OP_CLIP: begin
                xa_reg <= a_val - first_wl;
                xb_reg <= b_val - first_wl;
            end
            OP_TAKE0: y_reg <= $signed(ram_rdata);
            OP_RES_Y: begin
                res_reg <= (act_reg == ACT_INTEG) ? (64'(y_reg) <<< 4) : 64'(y_reg);
                st_reg  <= ST_OK;
            end
            OP_CLAMP: begin
                if (quo16 >= 16'(nm1)) begin
                    i_reg <= nm1 - IW'(1);
                    r_reg <= step;
                end else begin
                    i_reg <= IW'(quo16);
                    r_reg <= rem16;
                end
                if (cmd.xsel_b) begin
                    q_reg  <= IW'(quo16);
                    rb_reg <= rem16;
                end else begin
                    p_reg <= IW'(quo16) + IW'(rem16 != '0);
                    e_reg <= (rem16 != '0) ? step - rem16 : '0;
                end
            end
            OP_RD_I1:  v0_reg <= $signed(ram_rdata);
            OP_GET_V1: v1_reg <= $signed(ram_rdata);
            OP_MUL_D:  prod_reg <= prod_full;
            OP_NUM:    num_reg <= prod_reg + PROD_W'(step);
            OP_DIV_N:  neg_reg <= num_reg[PROD_W-1];
            OP_INTERP_END: begin
                y_reg <= y_full[31:0];
                if (cmd.xsel_b) begin
                    fb_reg <= y_full[31:0];
                end else begin
                    fa_reg <= y_full[31:0];
                end
            end
            OP_MUL_EDGE: prod_reg <= prod_full;
            OP_MUL_FIRST: begin
                prev_reg <= $signed(ram_rdata);
                prod_reg <= prod_full;
            end
            OP_ACC_SET:    acc_reg <= ACC_W'(prod_reg);
            OP_WALK_START: k_reg <= {1'b0, p_reg} + (IW+1)'(1);
            OP_WALK: begin
                if (iss) begin
                    k_reg <= k_reg + (IW+1)'(1);
                end
                if (rv_reg) begin
                    prev_reg <= $signed(ram_rdata);
                end
                if (pv_reg) begin
                    prod_reg <= prod_full;
                end
            end
            OP_MUL_LAST: prod_reg <= prod_full;
            OP_ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            OP_RES_ACC: begin
                res_reg <= 64'(acc_half);
                st_reg  <= ST_OK;
            end
            OP_EMIT: begin
                out_res_reg <= res_reg;
                out_st_reg  <= st_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        flags.act_write = act_reg == ACT_WRITE;
        flags.act_eval  = act_reg == ACT_EVAL;
        flags.act_integ = act_reg == ACT_INTEG;
        flags.idx_ok    = 32'(idx_reg) < 32'(n_val);
        flags.span_zero = span_reg == '0;
        flags.lo_eq_f   = lo_reg == first_wl;
        flags.lo_out    = (lo_reg < first_wl) || (SW'(lo_reg) > fspan);
        flags.lo_gt_hi  = lo_reg > hi_reg;
        flags.lo_eq_hi  = lo_reg == hi_reg;
        flags.a_gt_b    = a_val > b_val;
        flags.a_eq_b    = a_val == b_val;
        flags.p_gt_q    = p_reg > q_reg;
        flags.div_busy  = div_busy;
        flags.walk_done = !iss && !rv_reg && !pv_reg && !mv_reg;
    end

    assign out_result = out_res_reg;
    assign out_status = out_st_reg;

endmodule
`default_nettype wire

// File: hdl/scii_ctrl.sv
// Controller state machine: sequences datapath commands for each beat.
// Depends on scii_pkg for commands, flags and states.
`default_nettype none
module scii_ctrl
    import scii_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire dp_flags_t flags,
    output dp_cmd_t        cmd
);

    ctrl_state_t state_reg, state_next;
    logic        sel_b_reg, sel_b_next;
    logic        valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_b_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_b_reg <= sel_b_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        valid_next = valid_reg && !m_tready;
        cmd.op     = OP_NONE;
        cmd.xsel_b = sel_b_reg;
        cmd.code   = ST_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                sel_b_next = 1'b0;
                if (flags.act_write) begin
                    cmd.op     = flags.idx_ok ? OP_WRITE : OP_ZERO;
                    cmd.code   = ST_INDEX;
                    state_next = S_EMIT;
                end else if (flags.act_eval || (flags.act_integ && flags.lo_eq_hi)) begin
                    cmd.op     = OP_CLIP;
                    state_next = S_EVAL_CHK;
                end else if (flags.act_integ) begin
                    if (flags.lo_gt_hi) begin
                        cmd.op     = OP_ZERO;
                        cmd.code   = ST_ORDER;
                        state_next = S_EMIT;
                    end else begin
                        cmd.op     = OP_CLIP;
                        state_next = S_INT_CHK;
                    end
                end else begin
                    cmd.op     = OP_ZERO;
                    state_next = S_EMIT;
                end
            end
            S_EVAL_CHK: begin
                if (flags.span_zero) begin
                    if (flags.lo_eq_f) begin
                        state_next = S_RD0;
                    end else begin
                        cmd.op     = OP_ZERO;
                        cmd.code   = ST_SPAN;
                        state_next = S_EMIT;
                    end
                end else if (flags.lo_out) begin
                    cmd.op     = OP_ZERO;
                    cmd.code   = ST_SPAN;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_DIVX;
                end
            end
            S_INT_CHK: begin
                if (flags.a_gt_b) begin
                    cmd.op     = OP_ZERO;
                    cmd.code   = ST_SPAN;
                    state_next = S_EMIT;
                end else if (flags.a_eq_b || flags.span_zero) begin
                    cmd.op     = OP_ZERO;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_DIVX;
                end
            end
            S_RD0: begin
                cmd.op     = OP_RD0;
                state_next = S_TAKE0;
            end
            S_TAKE0: begin
                cmd.op     = OP_TAKE0;
                state_next = S_RES_Y;
            end
            S_RES_Y: begin
                cmd.op     = OP_RES_Y;
                state_next = S_EMIT;
            end
            S_DIVX: begin
                cmd.op     = OP_DIV_X;
                state_next = S_DIVX_W;
            end
            S_DIVX_W: begin
                if (!flags.div_busy) begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: begin
                cmd.op     = OP_CLAMP;
                state_next = S_RD_I;
            end
            S_RD_I: begin
                cmd.op     = OP_RD_I;
                state_next = S_RD_I1;
            end
            S_RD_I1: begin
                cmd.op     = OP_RD_I1;
                state_next = S_GET_V1;
            end
            S_GET_V1: begin
                cmd.op     = OP_GET_V1;
                state_next = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.op     = OP_MUL_D;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.op     = OP_NUM;
                state_next = S_DIVN;
            end
            S_DIVN: begin
                cmd.op     = OP_DIV_N;
                state_next = S_DIVN_W;
            end
            S_DIVN_W: begin
                if (!flags.div_busy) begin
                    state_next = S_IEND;
                end
            end
            S_IEND: begin
                cmd.op = OP_INTERP_END;
                if (flags.act_integ && !flags.lo_eq_hi) begin
                    if (!sel_b_reg) begin
                        sel_b_next = 1'b1;
                        state_next = S_DIVX;
                    end else begin
                        state_next = S_INT_PQ;
                    end
                end else begin
                    state_next = S_RES_Y;
                end
            end
            S_INT_PQ: begin
                state_next = flags.p_gt_q ? S_EDGE_MUL : S_RD_P;
            end
            S_EDGE_MUL: begin
                cmd.op     = OP_MUL_EDGE;
                state_next = S_EDGE_ACC;
            end
            S_EDGE_ACC: begin
                cmd.op     = OP_ACC_SET;
                state_next = S_RES_ACC;
            end
            S_RD_P: begin
                cmd.op     = OP_RD_P;
                state_next = S_FIRST_MUL;
            end
            S_FIRST_MUL: begin
                cmd.op     = OP_MUL_FIRST;
                state_next = S_FIRST_ACC;
            end
            S_FIRST_ACC: begin
                cmd.op     = OP_ACC_SET;
                state_next = S_WALK_START;
            end
            S_WALK_START: begin
                cmd.op     = OP_WALK_START;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (flags.walk_done) begin
                    state_next = S_LAST_MUL;
                end else begin
                    cmd.op = OP_WALK;
                end
            end
            S_LAST_MUL: begin
                cmd.op     = OP_MUL_LAST;
                state_next = S_LAST_ACC;
            end
            S_LAST_ACC: begin
                cmd.op     = OP_ACC_ADD;
                state_next = S_RES_ACC;
            end
            S_RES_ACC: begin
                cmd.op     = OP_RES_ACC;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!valid_reg || m_tready) begin
                    cmd.op     = OP_EMIT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = valid_reg;

endmodule
`default_nettype wire

// File: hdl/sampled_curve_interp_integrator_unit.sv
// Top level: configuration registers, controller and datapath.
// Depends on scii_pkg, scii_ctrl, scii_dp and assert_macros.svh.
//
//  channel   direction  payload
//  s_*       in         tuser: action; tdata: sample_index, sample_value, wave_lo, wave_hi
//  m_*       out        tuser: status; tdata: result_value
//  APB       in/out     first_wavelength @0, wavelength_step @4, sample_count @8
//
// An evaluation's time is set by the shared radix-2 divider (16 steps for the
// table position, 50 for rounding); an integration also walks the sample RAM,
// the walk being bound by its single port. Sample memory is not cleared by reset.
// A finished result holds in the output register while the next beat is accepted.
`default_nettype none
`include "assert_macros.svh"
module sampled_curve_interp_integrator_unit
    import scii_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [8:0] sample_index, [40:9] sample_value, [56:41] wave_lo, [72:57] wave_hi
    input  wire logic [79:0]       s_tdata,
    // [1:0] action
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [63:0] result_value
    output logic [63:0]            m_tdata,
    // [1:0] status
    output logic [1:0]             m_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic [15:0]        first_wl_reg;
    logic [15:0]        step_reg;
    logic [9:0]         count_reg;
    dp_cmd_t            cmd;
    dp_flags_t          flags;
    logic signed [63:0] out_result;
    status_t            out_status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_wl_reg <= 16'd6400;
            step_reg     <= 16'd5120;
            count_reg    <= 10'd2;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_FIRST_WL: first_wl_reg <= pwdata[15:0];
                REG_STEP:     step_reg     <= pwdata[15:0];
                REG_COUNT:    count_reg    <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FIRST_WL: prdata = {16'b0, first_wl_reg};
            REG_STEP:     prdata = {16'b0, step_reg};
            REG_COUNT:    prdata = {22'b0, count_reg};
            default:      prdata = '0;
        endcase
    end

    scii_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    scii_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .flags      (flags),
        .in_action  (s_tuser),
        .in_index   (s_tdata[8:0]),
        .in_value   ($signed(s_tdata[40:9])),
        .in_lo      (s_tdata[56:41]),
        .in_hi      (s_tdata[72:57]),
        .first_wl   (first_wl_reg),
        .step       (step_reg),
        .count      (count_reg),
        .out_result (out_result),
        .out_status (out_status)
    );

    assign m_tdata = out_result;
    assign m_tuser = out_status;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLY(a_error_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)

endmodule
`default_nettype wire
